### rtl/mie_pkg.sv
// ----------------------------------------------------------------------------
// mie_pkg
// shared types, constants and sha-256 tables for the mnemonic index encoder
// ----------------------------------------------------------------------------
package mie_pkg;

  localparam int EntropyBytes = 32;
  localparam int WordBits     = 11;
  localparam int WordCount    = 24;
  localparam int RoundCount   = 64;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCHED,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       init;
    logic       step;
    logic [5:0] round;
  } hash_ctl_t;

  typedef struct packed {
    logic [7:0] digest_byte;
  } hash_sts_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  localparam logic [255:0] InitH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

endpackage

### rtl/mie_round.sv
// ----------------------------------------------------------------------------
// mie_round
// sha-256 round unit: one compression round per step, schedule kept as a
// rolling 16-word window
// ----------------------------------------------------------------------------
module mie_round (
  input  logic               clk,
  input  logic [255:0]       message,
  input  mie_pkg::hash_ctl_t ctl,
  output mie_pkg::hash_sts_t sts
);
  import mie_pkg::*;

  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [31:0] x15, x2, wi, sg0, sg1, e1, a0, ch, maj, t1, t2;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    x15 = w[1];
    x2  = w[14];
    sg0 = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
    sg1 = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
    // first 16 rounds use the window as loaded
    if (ctl.round < 6'd16) begin
      wi = w[0];
    end else begin
      wi = w[0] + sg0 + w[9] + sg1;
    end
    e1  = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1  = v[7] + e1 + ch + round_k(ctl.round) + wi;
    a0  = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2  = a0 + maj;
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      for (int i = 0; i < 8; i++) begin
        w[i] <= message[255 - 32*i -: 32];
        v[i] <= InitH[255 - 32*i -: 32];
      end
      w[8] <= 32'h80000000;
      for (int i = 9; i < 15; i++) begin
        w[i] <= 32'h0;
      end
      w[15] <= 32'd256;
    end else if (ctl.step) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= wi;
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  logic [31:0] h0;
  assign h0 = InitH[255:224] + v[0];
  assign sts.digest_byte = h0[31:24];

endmodule

### rtl/mie_ctrl.sv
// ----------------------------------------------------------------------------
// mie_ctrl
// sequencer: byte loading, 64 hash rounds, checksum capture and word output
// ----------------------------------------------------------------------------
module mie_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         entropy_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [10:0]        word_code,
  output logic [4:0]         word_position,
  output logic               last_word,
  output logic [255:0]       message,
  output mie_pkg::hash_ctl_t ctl,
  input  mie_pkg::hash_sts_t sts
);
  import mie_pkg::*;

  state_t       state, state_next;
  logic [5:0]   bytes_loaded;
  logic [5:0]   round;
  logic [4:0]   word;
  logic [263:0] bits;
  logic         in_beat, out_beat;

  assign in_beat  = in_valid && !in_stall;
  assign out_beat = out_valid && !out_stall;
  assign message  = bits[263:8];
  assign in_stall = (state != ST_LOAD);
  assign out_valid = (state == ST_EMIT);
  assign word_code = bits[263 -: WordBits];
  assign word_position = word;
  assign last_word = (word == 5'(WordCount - 1));

  always_comb begin
    state_next = state;
    ctl.init   = 1'b0;
    ctl.step   = 1'b0;
    ctl.round  = round;
    case (state)
      ST_LOAD: begin
        if (in_beat && bytes_loaded == 6'(EntropyBytes - 1)) begin
          state_next = ST_SCHED;
        end
      end
      ST_SCHED: begin
        ctl.init   = 1'b1;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        ctl.step = 1'b1;
        if (round == 6'(RoundCount - 1)) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_beat && last_word) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_loaded <= '0;
      round        <= '0;
      word         <= '0;
    end else begin
      if (in_beat) begin
        bytes_loaded <= (bytes_loaded == 6'(EntropyBytes - 1)) ? '0 : bytes_loaded + 6'd1;
      end
      if (state == ST_SCHED) begin
        round <= '0;
      end else if (state == ST_ROUND) begin
        round <= round + 6'd1;
      end
      if (state == ST_FINAL) begin
        word <= '0;
      end else if (out_beat) begin
        word <= word + 5'd1;
      end
    end
  end

  // entropy shifts in at the bottom, then words shift out at the top
  always_ff @(posedge clk) begin
    if (in_beat) begin
      bits <= {bits[255:8], entropy_byte, 8'h00};
    end else if (state == ST_FINAL) begin
      bits[7:0] <= sts.digest_byte;
    end else if (out_beat) begin
      bits <= {bits[263-WordBits:0], {WordBits{1'b0}}};
    end
  end

endmodule

### rtl/mnemonic_index_encoder.sv
// ----------------------------------------------------------------------------
// mnemonic_index_encoder
// 256-bit entropy to 24 mnemonic word indices with sha-256 checksum
// ----------------------------------------------------------------------------
// input channel: one entropy byte per beat, most significant byte first.
// bytes 0..30 are taken one per cycle. after byte 31 the block stalls its
// input while the round unit runs: it loads the schedule, runs 64 sha-256
// rounds, then captures the checksum byte.
// output channel: 24 beats of word_code, word_position and last_word,
// one per cycle while out_stall is low; last_word marks position 23.
// the 64 rounds of a phrase run in turn through the shared round unit.
// a stalled output beat holds its fields; input stays stalled until the
// last word is taken.
// rst (synchronous) returns to loading with a zero byte count.
// ----------------------------------------------------------------------------
module mnemonic_index_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  entropy_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] word_code,
  output logic [4:0]  word_position,
  output logic        last_word
);
  import mie_pkg::*;

  hash_ctl_t    ctl;
  hash_sts_t    sts;
  logic [255:0] message;

  mie_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .entropy_byte,
    .out_valid, .out_stall, .word_code, .word_position, .last_word,
    .message, .ctl, .sts
  );

  mie_round u_round (
    .clk, .message, .ctl, .sts
  );

endmodule

### rtl/mie_checker.sv
// ----------------------------------------------------------------------------
// mie_checker
// port-level checks for the mnemonic index encoder
// ----------------------------------------------------------------------------
module mie_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [10:0] word_code,
  input logic [4:0]  word_position,
  input logic        last_word
);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open during output");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_position == 5'd23))) else $error("last flag");

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_word) |=>
      (out_valid && word_position == $past(word_position) + 5'd1)) else $error("position");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(word_code))) else $error("hold");

endmodule

bind mnemonic_index_encoder mie_checker u_mie_checker (.*);

### test/mie_checker.sv
// ----------------------------------------------------------------------------
// mie_scoreboard
// watches both channels of the mnemonic index encoder, computes the expected
// word indices with its own sha-256 and compares every output beat
// ----------------------------------------------------------------------------
module mie_scoreboard (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  entropy_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [10:0] word_code,
  input  logic [4:0]  word_position,
  input  logic        last_word,
  output int          fail_count,
  output int          words_pending
);

  typedef struct packed {
    logic [10:0] index;
    logic [4:0]  position;
    logic        last;
  } word_t;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] SHA_H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic [255:0] seed_bits;
  logic [5:0]   seed_count;
  word_t        expected_words[$];
  int           mismatches;

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // first byte of sha-256 over one 32-byte message
  function automatic logic [7:0] checksum_of(logic [255:0] msg);
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 8; i++) w[i] = msg[255 - 32*i -: 32];
    w[8] = 32'h80000000;
    for (int i = 9; i < 15; i++) w[i] = '0;
    w[15] = 32'd256;
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-7]
           + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
    {a, b, c, d, e, f, g, h} = {SHA_H0[0], SHA_H0[1], SHA_H0[2], SHA_H0[3],
                                SHA_H0[4], SHA_H0[5], SHA_H0[6], SHA_H0[7]};
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + SHA_K[i] + w[i];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    return 8'((SHA_H0[0] + a) >> 24);
  endfunction

  task automatic queue_phrase(logic [255:0] msg);
    logic [263:0] all_bits;
    word_t w;
    all_bits = {msg, checksum_of(msg)};
    for (int i = 0; i < 24; i++) begin
      w.index    = all_bits[263 - 11*i -: 11];
      w.position = 5'(i);
      w.last     = (i == 23);
      expected_words.push_back(w);
    end
  endtask

  assign fail_count = mismatches;

  always @(posedge clk) begin
    word_t exp_w;
    if (rst) begin
      seed_count <= '0;
      mismatches <= 0;
      expected_words.delete();
      words_pending <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (seed_count == 6'd31) begin
          queue_phrase({seed_bits[247:0], entropy_byte});
          seed_count <= '0;
        end else begin
          seed_count <= seed_count + 6'd1;
        end
        seed_bits <= {seed_bits[247:0], entropy_byte};
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected word beat: index %0d position %0d last %0b",
                     word_code, word_position, last_word);
          mismatches <= mismatches + 1;
        end else begin
          exp_w = expected_words.pop_front();
          if (exp_w.index !== word_code || exp_w.position !== word_position ||
              exp_w.last !== last_word) begin
            if (mismatches < 10)
              $display("word mismatch: expected %0d/%0d/%0b got %0d/%0d/%0b",
                       exp_w.index, exp_w.position, exp_w.last,
                       word_code, word_position, last_word);
            mismatches <= mismatches + 1;
          end
        end
      end
      words_pending <= expected_words.size();
    end
  end

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives entropy bytes with random gaps and output stalls into the encoder;
// the checker predicts and compares the word beats
// ----------------------------------------------------------------------------
module tb_top;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  entropy_byte;
  logic        out_valid;
  logic        out_stall;
  logic [10:0] word_code;
  logic [4:0]  word_position;
  logic        last_word;
  int          fail_count;
  int          words_pending;
  int          cycle_count;
  bit          stim_done;

  mnemonic_index_encoder dut (.*);

  mie_scoreboard u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: random stall lengths, with quiet stretches
  initial begin
    int hold;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (out_valid && !out_stall && !cycle_count[9])
          hold = $urandom_range(0, 3);
      end
    end
  end

  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = cycle_count[10] ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    entropy_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_phrase(int kind);
    for (int i = 0; i < 32; i++) begin
      case (kind)
        0:       send_byte(8'h00);
        1:       send_byte(8'hff);
        2:       send_byte((i % 2) ? 8'h55 : 8'haa);
        default: send_byte(8'($urandom));
      endcase
    end
  endtask

  initial begin
    in_valid     <= 1'b0;
    entropy_byte <= '0;
    rst          <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // all zeros, all ones, alternating bits
    send_phrase(0);
    send_phrase(1);
    send_phrase(2);
    in_valid <= 1'b0;
    // let the encoder drain completely before continuing
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    for (int p = 0; p < 6; p++) send_phrase(3);
    // a partial phrase: no words until the rest arrives
    for (int i = 0; i < 5; i++) send_byte(8'($urandom));
    in_valid <= 1'b0;
    repeat (20) @(posedge clk);
    for (int i = 0; i < 27; i++) send_byte(8'($urandom));
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    stim_done = 1'b1;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (stim_done && words_pending == 0) begin
        repeat (100) @(posedge clk);
        if (fail_count == 0)
          $display("Simulation PASSED");
        else
          $display("Simulation FAILED");
        $finish;
      end
      if (cycle_count > 200000) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule
